>>> sv/bta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the binary to ASCII number formatter.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned NumCells  = 10;
  localparam int unsigned ValBits   = 32;
  localparam int unsigned HexDigits = 8;
  localparam int unsigned CharBits  = 7;

  localparam logic [CharBits-1:0] ChrZero = 7'h30;
  localparam logic [CharBits-1:0] ChrX    = 7'h78;

  typedef struct packed {
    logic load;
    logic dabble;
    logic slide;
  } bta_cell_ctrl_t;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StConv    = 6'b000010,
    StSkip    = 6'b000100,
    StPrefix0 = 6'b001000,
    StPrefixX = 6'b010000,
    StEmit    = 6'b100000
  } bta_state_e;

  localparam logic [CharBits-1:0] Glyphs [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  function automatic logic [CharBits-1:0] glyph(input logic [3:0] nib);
    return Glyphs[nib];
  endfunction

endpackage
`default_nettype wire

>>> sv/bta_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bta_cell
// One digit cell: shift-and-add-3 step, parallel load and digit slide.
// ----------------------------------------------------------------------------
module bta_cell
  import bta_pkg::*;
(
  input  wire logic           clk_i,
  input  wire bta_cell_ctrl_t ctrl_i,
  input  wire logic [3:0]     load_digit_i,
  input  wire logic           bit_i,
  input  wire logic [3:0]     digit_i,
  output logic                bit_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.slide) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

endmodule
`default_nettype wire

>>> sv/binary_to_ascii_number_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter
// Formats a 32-bit number as decimal or 0x-prefixed hex ASCII text.
//
// Channel   Direction  Handshake               Payload
// input     in         start & !busy           kind_i, value_i
// result    out        valid_o, one cycle      char_code_o, last_o
//
// Decimal loads the number, runs the double-dabble shifts over all value bits,
// drops leading zeros and then sends the characters, one per cycle. Hex loads
// the number and sends the 0x prefix and the eight digits the same way.
// busy is high until the last beat of a number is on the result ports.
// Reset is asynchronous. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter
  import bta_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                kind_i,
  input  wire logic [ValBits-1:0]  value_i,
  output logic                     valid_o,
  output logic [CharBits-1:0]      char_code_o,
  output logic                     last_o
);

  bta_state_e state_q, state_d;
  logic [ValBits-1:0] value_q, value_d;
  logic [4:0] bit_cnt_q, bit_cnt_d;
  logic [3:0] dig_cnt_q, dig_cnt_d;
  logic valid_q, valid_d;
  logic last_q, last_d;
  logic [CharBits-1:0] char_q, char_d;
  bta_cell_ctrl_t ctrl;
  logic accept;

  logic [3:0] cell_digit [NumCells];
  logic       cell_bit   [NumCells];
  logic [3:0] top_digit;

  assign accept    = start && (state_q == StIdle);
  assign top_digit = cell_digit[NumCells-1];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [3:0] load_digit;
    logic       bit_in;
    logic [3:0] digit_in;
    if (i >= NumCells - HexDigits) begin : g_hex
      assign load_digit = kind_i ? value_i[(i-(NumCells-HexDigits))*4 +: 4] : 4'd0;
    end else begin : g_zero
      assign load_digit = 4'd0;
    end
    if (i == 0) begin : g_first
      assign bit_in   = value_q[ValBits-1];
      assign digit_in = 4'd0;
    end else begin : g_next
      assign bit_in   = cell_bit[i-1];
      assign digit_in = cell_digit[i-1];
    end
    bta_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .load_digit_i (load_digit),
      .bit_i        (bit_in),
      .digit_i      (digit_in),
      .bit_o        (cell_bit[i]),
      .digit_o      (cell_digit[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    char_d    = char_q;
    ctrl      = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl.load = 1'b1;
          value_d   = value_i;
          bit_cnt_d = '0;
          if (kind_i) begin
            dig_cnt_d = 4'(HexDigits);
            state_d   = StPrefix0;
          end else begin
            dig_cnt_d = 4'(NumCells);
            state_d   = StConv;
          end
        end
      end
      StConv: begin
        ctrl.dabble = 1'b1;
        value_d     = {value_q[ValBits-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q + 5'd1;
        if (bit_cnt_q == 5'(ValBits - 1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && dig_cnt_q > 4'd1) begin
          ctrl.slide = 1'b1;
          dig_cnt_d  = dig_cnt_q - 4'd1;
        end else begin
          state_d = StEmit;
        end
      end
      StPrefix0: begin
        valid_d = 1'b1;
        char_d  = ChrZero;
        state_d = StPrefixX;
      end
      StPrefixX: begin
        valid_d = 1'b1;
        char_d  = ChrX;
        state_d = StEmit;
      end
      StEmit: begin
        valid_d    = 1'b1;
        char_d     = glyph(top_digit);
        last_d     = (dig_cnt_q == 4'd1);
        ctrl.slide = 1'b1;
        dig_cnt_d  = dig_cnt_q - 4'd1;
        if (dig_cnt_q == 4'd1) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    char_q  <= char_d;
  end

  assign busy        = (state_q != StIdle);
  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && bit_cnt_q == 5'(ValBits - 1)) |=> (state_q == StSkip))
    else $error("double dabble did not end after the last bit");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (state_q == StIdle))
    else $error("last beat shown while the formatter is still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted number did not raise busy");

  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (dig_cnt_q != 4'd0))
    else $error("digit count ran out while emitting");

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary to ASCII number formatter. Numbers are
// sent in decimal and hex form, first as a directed set of edge values and
// then as random values in three phases with different sender gaps. A
// scoreboard predicts the character beats of every accepted number and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bta_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 60;

  localparam logic KindDec = 1'b0;
  localparam logic KindHex = 1'b1;

  localparam logic [CharBits-1:0] ChrUpperA = 7'h41;

  typedef struct packed {
    logic [CharBits-1:0] code;
    logic                last;
  } char_beat_t;

  class char_scoreboard;
    char_beat_t  expected_chars[$];
    int unsigned mismatches;

    task report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    function void note_number(input logic kind, input logic [ValBits-1:0] value);
      logic [3:0]          dec_digits[NumCells];
      logic [ValBits-1:0]  rest;
      logic [3:0]          nib;
      logic [CharBits-1:0] code;
      int                  n;
      int                  k;
      if (kind == KindHex) begin
        expected_chars.push_back('{code: ChrZero, last: 1'b0});
        expected_chars.push_back('{code: ChrX, last: 1'b0});
        for (k = 0; k < HexDigits; k++) begin
          nib  = value[ValBits-1-4*k -: 4];
          code = (nib < 4'd10) ? CharBits'(ChrZero + nib) : CharBits'(ChrUpperA + nib - 4'd10);
          expected_chars.push_back('{code: code, last: (k == HexDigits - 1)});
        end
      end else begin
        rest = value;
        n    = 0;
        do begin
          dec_digits[n] = 4'(rest % 10);
          rest          = rest / 10;
          n++;
        end while (rest != 0);
        for (k = n - 1; k >= 0; k--) begin
          expected_chars.push_back('{code: CharBits'(ChrZero + dec_digits[k]), last: (k == 0)});
        end
      end
    endfunction

    task check_char(input logic [CharBits-1:0] code, input logic last);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat code=%h last=%b", code, last));
      end else begin
        want = expected_chars.pop_front();
        if (code !== want.code) begin
          report_mismatch($sformatf("char_code %h, expected %h", code, want.code));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
        end
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                kind_i;
  logic [ValBits-1:0]  value_i;
  logic                valid_o;
  logic [CharBits-1:0] char_code_o;
  logic                last_o;

  int unsigned    cycle_count = 0;
  char_scoreboard sb;

  binary_to_ascii_number_formatter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_char(char_code_o, last_o);
    end
  end

  task send_number(input logic kind, input logic [ValBits-1:0] value,
                   input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start   <= 1'b0;
      kind_i  <= 1'($urandom);
      value_i <= $urandom;
    end
    @(negedge clk_i);
    start   <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    sb.note_number(kind, value);
  endtask

  task run_random_phase(input int unsigned count, input int unsigned idle_pct);
    logic [ValBits-1:0] value;
    logic [ValBits-1:0] pow;
    repeat (count) begin
      case ($urandom_range(3))
        0: value = $urandom;
        1: value = $urandom >> $urandom_range(31);
        2: value = $urandom_range(999);
        default: begin
          pow = 1;
          repeat ($urandom_range(9)) pow = pow * 10;
          value = pow - $urandom_range(1);
        end
      endcase
      send_number(1'($urandom), value, idle_pct);
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KindDec;
    value_i     = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_number(KindDec, 32'd0, 0);
    send_number(KindDec, 32'd1, 0);
    send_number(KindDec, 32'd9, 0);
    send_number(KindDec, 32'd10, 0);
    send_number(KindDec, 32'd99, 0);
    send_number(KindDec, 32'd100, 0);
    send_number(KindDec, 32'd999999999, 0);
    send_number(KindDec, 32'd1000000000, 0);
    send_number(KindDec, 32'd2147483648, 0);
    send_number(KindDec, 32'd4294967294, 0);
    send_number(KindDec, 32'd4294967295, 0);
    send_number(KindHex, 32'h0000_0000, 0);
    send_number(KindHex, 32'hFFFF_FFFF, 0);
    send_number(KindHex, 32'h1234_5678, 0);
    send_number(KindHex, 32'h89AB_CDEF, 0);
    send_number(KindHex, 32'hA5A5_A5A5, 0);
    send_number(KindHex, 32'h5A5A_5A5A, 0);
    send_number(KindHex, 32'hFEDC_BA98, 0);

    run_random_phase(70, 28);
    run_random_phase(70, 65);
    run_random_phase(72, 0);

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
